FILE: rtl/ffge_pkg.sv
package ffge_pkg;

    localparam int DIV_BITS  = 40;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 18;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_SETPOINT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONV_RATIO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCUM_STEP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_GAIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_GAIN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_COEF  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROLL_SCALE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_SCALE  = 3'd7;

    typedef logic signed [31:0] t_q16;

    // Saturate a wide signed value to 32 bits.
    function automatic t_q16 sat32(input logic signed [51:0] v);
        t_q16 res;
        if (v > 52'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -52'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

FILE: rtl/feedforward_gain_estimator.sv
// Flow: an inactive or disabled tick goes straight to the output; an active tick runs each
//   learning axis through a divide, filter and clamp (the first one latches base gains first);
//   an exit while armed divides each correction back into gain units.
// Throughput: one word at a time; o_ready returns in the cycle after the result is queued.
//   A held result stalls the input.
// Reset: synchronous, active low; clears sequencer, configuration (scales to one), state.
module feedforward_gain_estimator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [ffge_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ffge_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    // input channel
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_armed,
    input  logic                               i_mode_ok,
    input  logic [9:0]                         i_roll_gain_now,
    input  logic [9:0]                         i_pitch_gain_now,
    input  logic signed [23:0]                 i_roll_setpoint,
    input  logic signed [23:0]                 i_roll_gyro,
    input  logic signed [23:0]                 i_roll_iterm,
    input  logic signed [23:0]                 i_pitch_setpoint,
    input  logic signed [23:0]                 i_pitch_gyro,
    input  logic signed [23:0]                 i_pitch_iterm,
    // output channel
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_active,
    output logic signed [31:0]                 o_roll_correction,
    output logic signed [31:0]                 o_pitch_correction,
    output logic                               o_gains_written,
    output logic [9:0]                         o_new_roll_gain,
    output logic [9:0]                         o_new_pitch_gain
);

    // Sequencer codes
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_START = 5'd1;
    localparam logic [4:0] S_BASE  = 5'd2;
    localparam logic [4:0] S_BASEW = 5'd3;
    localparam logic [4:0] S_QUAL  = 5'd4;
    localparam logic [4:0] S_CONV  = 5'd5;
    localparam logic [4:0] S_DIV   = 5'd6;
    localparam logic [4:0] S_RATIO = 5'd7;
    localparam logic [4:0] S_FILT  = 5'd8;
    localparam logic [4:0] S_FUPD  = 5'd9;
    localparam logic [4:0] S_INC   = 5'd10;
    localparam logic [4:0] S_SUM   = 5'd11;
    localparam logic [4:0] S_LO    = 5'd12;
    localparam logic [4:0] S_HI    = 5'd13;
    localparam logic [4:0] S_CLOAD = 5'd14;
    localparam logic [4:0] S_CDIV  = 5'd15;
    localparam logic [4:0] S_CFIN  = 5'd16;
    localparam logic [4:0] S_OUT   = 5'd17;

    localparam logic [5:0] DIV_LAST = 6'(ffge_pkg::DIV_BITS - 1);

    // Configuration registers
    logic [17:0] r_min_sp;
    logic [15:0] r_conv, r_step, r_coef, r_rscale, r_pscale;
    logic [9:0]  r_min_gain, r_max_gain;

    // Estimator state
    logic               r_was_active;
    ffge_pkg::t_q16     r_filt [2];
    ffge_pkg::t_q16     r_base [2];
    ffge_pkg::t_q16     r_corr [2];

    // Latched word
    logic               r_armed, r_mode;
    logic [9:0]         r_gain [2];
    logic signed [23:0] r_sp [2];
    logic signed [23:0] r_gy [2];
    logic signed [23:0] r_it [2];

    // Sequencer and working registers
    logic [4:0]         r_state;
    logic               r_ax;
    logic               r_res_act, r_res_gw;
    logic [9:0]         r_ng [2];
    logic signed [50:0] r_prod;
    logic signed [50:0] r_lo;
    logic signed [51:0] r_total;
    ffge_pkg::t_q16     r_ratio;

    // Shared divider
    logic [39:0] r_dq;
    logic [23:0] r_dr;
    logic [23:0] r_dd;
    logic [5:0]  r_cnt;

    // Output register
    logic               r_o_valid;
    logic               r_o_act, r_o_gw;
    logic signed [31:0] r_o_rc, r_o_pc;
    logic [9:0]         r_o_rg, r_o_pg;

    // ---------------------------------------------------------------
    // Axis selection and qualification
    // ---------------------------------------------------------------
    logic [15:0]        w_scale;
    logic signed [23:0] w_sp, w_gy, w_it;
    logic [23:0]        w_asp, w_ait;
    logic signed [24:0] w_ed;
    logic [24:0]        w_aed;
    logic               w_act;

    assign w_scale = r_ax ? r_pscale : r_rscale;
    assign w_sp    = r_sp[r_ax];
    assign w_gy    = r_gy[r_ax];
    assign w_it    = r_it[r_ax];
    assign w_asp   = w_sp[23] ? (~w_sp + 24'd1) : w_sp;
    assign w_ait   = w_it[23] ? (~w_it + 24'd1) : w_it;
    assign w_ed    = {w_gy[23], w_gy} - {w_sp[23], w_sp};
    assign w_aed   = w_ed[24] ? (~w_ed + 25'd1) : w_ed;

    // Active needs arming, mode permission and both gains inside the limits.
    assign w_act = r_armed && r_mode
                && (r_gain[0] >= r_min_gain) && (r_gain[0] <= r_max_gain)
                && (r_gain[1] >= r_min_gain) && (r_gain[1] <= r_max_gain);

    // ---------------------------------------------------------------
    // Shared multiplier: 17-bit signed by 34-bit signed, registered
    // ---------------------------------------------------------------
    logic [15:0]        w_mul_a;
    logic signed [33:0] w_mul_b;
    logic signed [50:0] w_prod;
    logic signed [32:0] w_fdiff;
    ffge_pkg::t_q16     w_y;

    assign w_y     = r_filt[r_ax];
    assign w_fdiff = $signed({r_ratio[31], r_ratio}) - $signed({w_y[31], w_y});

    always_comb begin
        unique case (r_state)
            S_BASE: begin
                w_mul_a = w_scale;
                w_mul_b = $signed({24'd0, r_gain[r_ax]});
            end
            S_QUAL: begin
                w_mul_a = r_conv;
                w_mul_b = $signed({10'd0, w_asp});
            end
            S_FILT: begin
                w_mul_a = r_coef;
                w_mul_b = $signed({w_fdiff[32], w_fdiff});
            end
            S_INC: begin
                w_mul_a = r_step;
                w_mul_b = $signed({{2{w_y[31]}}, w_y});
            end
            S_SUM: begin
                w_mul_a = w_scale;
                w_mul_b = $signed({24'd0, r_min_gain});
            end
            S_LO: begin
                w_mul_a = w_scale;
                w_mul_b = $signed({24'd0, r_max_gain});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = $signed({1'b0, w_mul_a}) * w_mul_b;

    // Round half up, floor shift by 16.
    logic signed [50:0] w_rnd;
    assign w_rnd = (r_prod + 51'sd32768) >>> 16;

    // Filter update
    logic signed [51:0] w_ysum;
    assign w_ysum = $signed({w_rnd[50], w_rnd}) + $signed({{20{w_y[31]}}, w_y});

    // Running total of base, correction and step
    logic signed [51:0] w_sum;
    assign w_sum = $signed({{20{r_base[r_ax][31]}}, r_base[r_ax]})
                 + $signed({{20{r_corr[r_ax][31]}}, r_corr[r_ax]})
                 + $signed({w_rnd[50], w_rnd});

    // Clamp total against the scaled limits, lower bound first.
    logic signed [51:0] w_clamp, w_cdiff;
    always_comb begin
        if (r_total < $signed({r_lo[50], r_lo})) begin
            w_clamp = $signed({r_lo[50], r_lo});
        end else if (r_total > $signed({r_prod[50], r_prod})) begin
            w_clamp = $signed({r_prod[50], r_prod});
        end else begin
            w_clamp = r_total;
        end
    end
    assign w_cdiff = w_clamp - $signed({{20{r_base[r_ax][31]}}, r_base[r_ax]});

    // ---------------------------------------------------------------
    // Shared divider step: restoring, one quotient bit per cycle
    // ---------------------------------------------------------------
    logic [24:0] w_dt;
    logic        w_dge;
    assign w_dt  = {r_dr, r_dq[39]};
    assign w_dge = (w_dt >= {1'b0, r_dd});

    // Ratio sign and saturation
    logic           w_rneg;
    ffge_pkg::t_q16 w_rsat;
    assign w_rneg = w_it[23] ^ w_sp[23];
    always_comb begin
        if (!w_rneg) begin
            w_rsat = (r_dq > 40'h00_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(r_dq[31:0]);
        end else begin
            w_rsat = (r_dq > 40'h00_8000_0000) ? 32'sh8000_0000
                                               : $signed(~r_dq[31:0] + 32'd1);
        end
    end

    // Commit: round to nearest, ties to even, then add and clamp.
    logic [32:0]        w_corr_abs;
    logic [24:0]        w_r2;
    logic               w_up;
    logic [32:0]        w_qr;
    logic signed [33:0] w_sq;
    logic signed [34:0] w_g;
    logic [9:0]         w_gclamp;
    assign w_corr_abs = r_corr[r_ax][31] ? (~{1'b1, r_corr[r_ax]} + 33'd1)
                                         : {1'b0, r_corr[r_ax]};
    assign w_r2 = {r_dr, 1'b0};
    assign w_up = (w_r2 > {1'b0, r_dd}) || ((w_r2 == {1'b0, r_dd}) && r_dq[0]);
    assign w_qr = r_dq[32:0] + {32'd0, w_up};
    assign w_sq = r_corr[r_ax][31] ? -$signed({1'b0, w_qr}) : $signed({1'b0, w_qr});
    assign w_g  = $signed({25'd0, r_gain[r_ax]}) + $signed({w_sq[33], w_sq});
    always_comb begin
        if (w_g < $signed({25'd0, r_min_gain})) begin
            w_gclamp = r_min_gain;
        end else if (w_g > $signed({25'd0, r_max_gain})) begin
            w_gclamp = r_max_gain;
        end else begin
            w_gclamp = w_g[9:0];
        end
    end

    // Output register frees when empty or taken.
    logic w_out_load;
    assign w_out_load = (r_state == S_OUT) && (!r_o_valid || i_ready);

    assign o_ready = (r_state == S_IDLE);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_sp   <= '0;
            r_conv     <= '0;
            r_step     <= '0;
            r_min_gain <= '0;
            r_max_gain <= '0;
            r_coef     <= '0;
            r_rscale   <= 16'd1;
            r_pscale   <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ffge_pkg::REG_MIN_SETPOINT: r_min_sp   <= i_cfg_data;
                ffge_pkg::REG_CONV_RATIO:   r_conv     <= i_cfg_data[15:0];
                ffge_pkg::REG_ACCUM_STEP:   r_step     <= i_cfg_data[15:0];
                ffge_pkg::REG_MIN_GAIN:     r_min_gain <= i_cfg_data[9:0];
                ffge_pkg::REG_MAX_GAIN:     r_max_gain <= i_cfg_data[9:0];
                ffge_pkg::REG_FILTER_COEF:  r_coef     <= i_cfg_data[15:0];
                ffge_pkg::REG_ROLL_SCALE:   r_rscale   <= i_cfg_data[15:0];
                ffge_pkg::REG_PITCH_SCALE:  r_pscale   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Multiplier output register and latched word (payload, no reset)
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (i_valid && o_ready) begin
            r_armed  <= i_armed;
            r_mode   <= i_mode_ok;
            r_gain[0] <= i_roll_gain_now;
            r_gain[1] <= i_pitch_gain_now;
            r_sp[0]  <= i_roll_setpoint;
            r_gy[0]  <= i_roll_gyro;
            r_it[0]  <= i_roll_iterm;
            r_sp[1]  <= i_pitch_setpoint;
            r_gy[1]  <= i_pitch_gyro;
            r_it[1]  <= i_pitch_iterm;
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_was_active <= 1'b0;
            r_ax         <= 1'b0;
            r_res_act    <= 1'b0;
            r_res_gw     <= 1'b0;
            r_cnt        <= '0;
            for (int k = 0; k < 2; k++) begin
                r_filt[k] <= '0;
                r_base[k] <= '0;
                r_corr[k] <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_res_act <= 1'b0;
                    r_res_gw  <= 1'b0;
                    r_ax      <= 1'b0;
                    if (r_step == '0) begin
                        // disabled: leave state untouched, emit zeros
                        r_state <= S_OUT;
                    end else if (w_act) begin
                        r_state <= r_was_active ? S_QUAL : S_BASE;
                    end else if (r_was_active && r_armed) begin
                        r_state <= S_CLOAD;
                    end else begin
                        if (r_was_active) begin
                            r_corr[0] <= '0;
                            r_corr[1] <= '0;
                        end
                        r_was_active <= 1'b0;
                        r_state      <= S_OUT;
                    end
                end
                S_BASE: begin
                    r_state <= S_BASEW;
                end
                S_BASEW: begin
                    // latch base gain, clear filter and correction on entry
                    r_base[r_ax] <= r_prod[31:0];
                    r_filt[r_ax] <= '0;
                    r_corr[r_ax] <= '0;
                    r_ax         <= ~r_ax;
                    r_state      <= r_ax ? S_QUAL : S_BASE;
                end
                S_QUAL: begin
                    if ((w_sp == '0) || (w_asp < {6'd0, r_min_sp})) begin
                        if (r_ax) begin
                            r_was_active <= 1'b1;
                            r_res_act    <= 1'b1;
                            r_state      <= S_OUT;
                        end else begin
                            r_ax <= 1'b1;
                        end
                    end else begin
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    if ({w_aed, 16'd0} > r_prod[40:0]) begin
                        // tracking not converged: drop this axis
                        if (r_ax) begin
                            r_was_active <= 1'b1;
                            r_res_act    <= 1'b1;
                            r_state      <= S_OUT;
                        end else begin
                            r_ax    <= 1'b1;
                            r_state <= S_QUAL;
                        end
                    end else begin
                        r_dq    <= {w_ait, 16'd0};
                        r_dr    <= '0;
                        r_dd    <= w_asp;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV, S_CDIV: begin
                    r_dr  <= w_dge ? 24'(w_dt - {1'b0, r_dd}) : w_dt[23:0];
                    r_dq  <= {r_dq[38:0], w_dge};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == DIV_LAST) begin
                        r_state <= (r_state == S_DIV) ? S_RATIO : S_CFIN;
                    end
                end
                S_RATIO: begin
                    r_ratio <= w_rsat;
                    r_state <= S_FILT;
                end
                S_FILT: begin
                    r_state <= S_FUPD;
                end
                S_FUPD: begin
                    r_filt[r_ax] <= ffge_pkg::sat32(w_ysum);
                    r_state      <= S_INC;
                end
                S_INC: begin
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_total <= w_sum;
                    r_state <= S_LO;
                end
                S_LO: begin
                    r_lo    <= r_prod;
                    r_state <= S_HI;
                end
                S_HI: begin
                    r_corr[r_ax] <= ffge_pkg::sat32(w_cdiff);
                    if (r_ax) begin
                        r_was_active <= 1'b1;
                        r_res_act    <= 1'b1;
                        r_state      <= S_OUT;
                    end else begin
                        r_ax    <= 1'b1;
                        r_state <= S_QUAL;
                    end
                end
                S_CLOAD: begin
                    // convert correction to user units: |corr| / scale
                    r_dq    <= {7'd0, w_corr_abs};
                    r_dr    <= '0;
                    r_dd    <= {8'd0, (w_scale == '0) ? 16'd1 : w_scale};
                    r_cnt   <= '0;
                    r_state <= S_CDIV;
                end
                S_CFIN: begin
                    r_ng[r_ax] <= w_gclamp;
                    if (r_ax) begin
                        r_corr[0]    <= '0;
                        r_corr[1]    <= '0;
                        r_was_active <= 1'b0;
                        r_res_gw     <= 1'b1;
                        r_state      <= S_OUT;
                    end else begin
                        r_ax    <= 1'b1;
                        r_state <= S_CLOAD;
                    end
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_act <= r_res_act;
            r_o_gw  <= r_res_gw;
            r_o_rc  <= r_res_act ? r_corr[0] : '0;
            r_o_pc  <= r_res_act ? r_corr[1] : '0;
            r_o_rg  <= r_res_gw ? r_ng[0] : '0;
            r_o_pg  <= r_res_gw ? r_ng[1] : '0;
        end
    end

    assign o_valid            = r_o_valid;
    assign o_active           = r_o_act;
    assign o_gains_written    = r_o_gw;
    assign o_roll_correction  = r_o_rc;
    assign o_pitch_correction = r_o_pc;
    assign o_new_roll_gain    = r_o_rg;
    assign o_new_pitch_gain   = r_o_pg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_START))
        else $error("accepted word did not start the sequencer");

    a_inactive_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_active) |-> (o_roll_correction == '0 && o_pitch_correction == '0))
        else $error("corrections nonzero while inactive");

    a_gw_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_gains_written) |-> !o_active)
        else $error("gains written while active");

    a_no_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_gains_written) |-> (o_new_roll_gain == '0 && o_new_pitch_gain == '0))
        else $error("gains nonzero without commit");

endmodule
